/* hdl/rotated_sorted_array_search_core_assert.svh */
// ---------------------------------------------------------------------------
// Rotated sorted array search - assertion macros
// Concurrent assertion wrappers; they compile away under SYNTHESIS.
// ---------------------------------------------------------------------------
`ifndef ROTATED_SORTED_ARRAY_SEARCH_CORE_ASSERT_SVH
`define ROTATED_SORTED_ARRAY_SEARCH_CORE_ASSERT_SVH

`ifndef SYNTHESIS
// property must hold at every clock outside reset
`define RSAS_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("rsas assertion failed");
// expression must never be true outside reset
`define RSAS_NEVER(lbl, clk, rst, expr) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) \
    else $error("rsas forbidden condition seen");
`else
`define RSAS_ASSERT(lbl, clk, rst, prop)
`define RSAS_NEVER(lbl, clk, rst, expr)
`endif

`endif

/* hdl/rsas_pkg.sv */
// ---------------------------------------------------------------------------
// Rotated sorted array search - package
// Sizes, command codes, sequencer states and shared payload types.
// ---------------------------------------------------------------------------
package rsas_pkg;

  localparam int DEPTH = 128;
  localparam int DW    = 32;
  localparam int AW    = $clog2(DEPTH);  // element index
  localparam int CW    = AW + 1;         // element count, holds DEPTH
  localparam int IW    = AW + 2;         // signed search bound, holds -1 and DEPTH

  localparam logic CMD_APPEND = 1'b0;
  localparam logic CMD_SEARCH = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FIRST,
    ST_PCHK,
    ST_PMID,
    ST_PNXT,
    ST_PPRV,
    ST_PICK,
    ST_SCHK,
    ST_SCMP,
    ST_FIN
  } state_t;

  typedef struct packed {
    logic                 cmd;
    logic signed [DW-1:0] value;
  } req_t;

  typedef struct packed {
    logic          found;
    logic [AW-1:0] position;
  } res_t;

endpackage

/* hdl/rsas_if.sv */
// ---------------------------------------------------------------------------
// Rotated sorted array search - channel interfaces
// Request channel (cmd, value) and response channel (found, position).
// ---------------------------------------------------------------------------
interface rsas_req_if;
  import rsas_pkg::*;
  logic                 valid;
  logic                 ready;
  logic                 cmd;
  logic signed [DW-1:0] value;
  modport source (output valid, cmd, value, input ready);
  modport sink   (input valid, cmd, value, output ready);
endinterface

interface rsas_rsp_if;
  import rsas_pkg::*;
  logic          valid;
  logic          ready;
  logic          found;
  logic [AW-1:0] position;
  modport source (output valid, found, position, input ready);
  modport sink   (input valid, found, position, output ready);
endinterface

/* hdl/rsas_ram.sv */
// ---------------------------------------------------------------------------
// Rotated sorted array search - element memory
// Simple dual port RAM, one write port, one read port with registered data.
// ---------------------------------------------------------------------------
module rsas_ram #(
  parameter int WIDTH = 32,
  parameter int ABITS = 7
) (
  input  logic             clk,
  input  logic             we,
  input  logic [ABITS-1:0] waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [ABITS-1:0] raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [2**ABITS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

/* hdl/rsas_ctrl.sv */
// ---------------------------------------------------------------------------
// Rotated sorted array search - search sequencer
// Appends into the element memory and runs the pivot and binary searches.
// ---------------------------------------------------------------------------
`include "rotated_sorted_array_search_core_assert.svh"

module rsas_ctrl (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      acc,
  input  rsas_pkg::req_t            req,
  output logic                      idle,
  output logic                      res_valid,
  output rsas_pkg::res_t            res,
  input  logic                      res_take,
  output logic                      we,
  output logic [rsas_pkg::AW-1:0]   waddr,
  output logic [rsas_pkg::DW-1:0]   wdata,
  output logic [rsas_pkg::AW-1:0]   raddr,
  input  logic [rsas_pkg::DW-1:0]   rdata
);
  import rsas_pkg::*;

  state_t state, state_next;

  logic [CW-1:0]        count, count_next;
  logic signed [IW-1:0] lo, lo_next, hi, hi_next;
  logic [AW-1:0]        mid, mid_next, pidx, pidx_next;
  logic signed [DW-1:0] key, key_next;
  logic signed [DW-1:0] e_first, e_first_next, e_lo, e_lo_next;
  logic signed [DW-1:0] e_mid, e_mid_next, e_nxt, e_nxt_next, pval, pval_next;
  logic                 res_found, res_found_next;
  logic [AW-1:0]        res_pos, res_pos_next;

  logic signed [DW-1:0] rd;
  logic signed [IW-1:0] last, mid_c, mid_s, pidx_s, diff;

  assign rd     = $signed(rdata);
  assign last   = $signed({{(IW-CW){1'b0}}, count}) - IW'(1);
  assign diff   = hi - lo;
  assign mid_c  = lo + (diff >>> 1);
  assign mid_s  = $signed({{(IW-AW){1'b0}}, mid});
  assign pidx_s = $signed({{(IW-AW){1'b0}}, pidx});

  assign res.found    = res_found;
  assign res.position = res_pos;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    lo        <= lo_next;
    hi        <= hi_next;
    mid       <= mid_next;
    pidx      <= pidx_next;
    key       <= key_next;
    e_first   <= e_first_next;
    e_lo      <= e_lo_next;
    e_mid     <= e_mid_next;
    e_nxt     <= e_nxt_next;
    pval      <= pval_next;
    res_found <= res_found_next;
    res_pos   <= res_pos_next;
  end

  always_comb begin
    state_next     = state;
    count_next     = count;
    lo_next        = lo;
    hi_next        = hi;
    mid_next       = mid;
    pidx_next      = pidx;
    key_next       = key;
    e_first_next   = e_first;
    e_lo_next      = e_lo;
    e_mid_next     = e_mid;
    e_nxt_next     = e_nxt;
    pval_next      = pval;
    res_found_next = res_found;
    res_pos_next   = res_pos;
    idle           = 1'b0;
    res_valid      = 1'b0;
    we             = 1'b0;
    waddr          = count[AW-1:0];
    wdata          = req.value;
    raddr          = mid_c[AW-1:0];
    case (state)
      ST_IDLE: begin
        idle  = 1'b1;
        raddr = '0;  // first element, used if this is a query
        if (acc) begin
          key_next = req.value;
          if (req.cmd == CMD_APPEND) begin
            if (count < CW'(DEPTH)) begin
              we         = 1'b1;
              count_next = count + CW'(1);
            end
          end else if (count == '0) begin
            res_found_next = 1'b0;
            res_pos_next   = '0;
            state_next     = ST_FIN;
          end else begin
            state_next = ST_FIRST;
          end
        end
      end
      ST_FIRST: begin
        e_first_next = rd;
        e_lo_next    = rd;
        lo_next      = '0;
        hi_next      = last;
        state_next   = ST_PCHK;
      end
      // pivot search: read mid, mid+1, mid-1 back to back
      ST_PCHK: begin
        if (hi < lo) begin
          lo_next    = '0;
          hi_next    = last;
          state_next = ST_SCHK;
        end else if (lo == hi) begin
          pidx_next  = lo[AW-1:0];
          pval_next  = e_lo;
          state_next = ST_PICK;
        end else begin
          mid_next   = mid_c[AW-1:0];
          state_next = ST_PMID;
        end
      end
      ST_PMID: begin
        e_mid_next = rd;
        raddr      = mid + AW'(1);
        state_next = ST_PNXT;
      end
      ST_PNXT: begin
        e_nxt_next = rd;
        raddr      = mid - AW'(1);
        if (rd < e_mid) begin
          pidx_next  = mid;
          pval_next  = e_mid;
          state_next = ST_PICK;
        end else begin
          state_next = ST_PPRV;
        end
      end
      ST_PPRV: begin
        if (mid_s > lo && rd > e_mid) begin
          pidx_next  = mid - AW'(1);
          pval_next  = rd;
          state_next = ST_PICK;
        end else if (e_lo >= e_mid) begin
          hi_next    = mid_s - IW'(1);
          state_next = ST_PCHK;
        end else begin
          lo_next    = mid_s + IW'(1);
          e_lo_next  = e_nxt;  // new lo is mid+1, already read
          state_next = ST_PCHK;
        end
      end
      ST_PICK: begin
        if (pval == key) begin
          res_found_next = 1'b1;
          res_pos_next   = pidx;
          state_next     = ST_FIN;
        end else if (e_first <= key) begin
          lo_next    = '0;
          hi_next    = pidx_s;
          state_next = ST_SCHK;
        end else begin
          lo_next    = pidx_s + IW'(1);
          hi_next    = last;
          state_next = ST_SCHK;
        end
      end
      // binary search over [lo, hi]
      ST_SCHK: begin
        if (lo > hi) begin
          res_found_next = 1'b0;
          res_pos_next   = '0;
          state_next     = ST_FIN;
        end else begin
          mid_next   = mid_c[AW-1:0];
          state_next = ST_SCMP;
        end
      end
      ST_SCMP: begin
        if (rd == key) begin
          res_found_next = 1'b1;
          res_pos_next   = mid;
          state_next     = ST_FIN;
        end else if (rd > key) begin
          hi_next    = mid_s - IW'(1);
          state_next = ST_SCHK;
        end else begin
          lo_next    = mid_s + IW'(1);
          state_next = ST_SCHK;
        end
      end
      ST_FIN: begin
        res_valid = 1'b1;
        if (res_take) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  `RSAS_NEVER(a_count_over, clk, rst, count > CW'(DEPTH))
  `RSAS_ASSERT(a_full_drop, clk, rst, (acc && req.cmd == CMD_APPEND && count == CW'(DEPTH)) |=> $stable(count))
  `RSAS_ASSERT(a_empty_miss, clk, rst, (acc && req.cmd == CMD_SEARCH && count == '0) |=> (state == ST_FIN && !res_found))
  `RSAS_ASSERT(a_probe_range, clk, rst, (state == ST_SCMP) |-> ({1'b0, mid} < count))

endmodule

/* hdl/rotated_sorted_array_search_core.sv */
// ---------------------------------------------------------------------------
// Rotated sorted array search - top level
// Stores appended elements and answers key lookups in a rotated sorted array.
// ---------------------------------------------------------------------------
// Usage:
//   req: valid/ready channel with cmd and value. cmd 0 appends value to the
//        array (dropped once DEPTH elements are held), cmd 1 looks value up.
//   rsp: valid/ready channel with found and position, one transfer per
//        lookup, none per append. position is 0 when found is 0.
// Timing:
//   An append leaves the sequencer idle; the next request can transfer right
//   after. A lookup holds req.ready low while it runs: it fetches the first
//   element, then runs pivot steps (reads of mid, mid+1, mid-1 through the
//   single read port of the element memory), picks the half, runs binary
//   search steps and posts the result. A lookup ends early when the pivot
//   or the key is hit early.
// Reset: rst (synchronous) empties the array; memory contents are not
//   cleared, entries at or above the count never affect a lookup.
// Stall: the result sits in an output register; the sequencer waits in its
//   final state only while that register is full and rsp.ready is low.
// ---------------------------------------------------------------------------
module rotated_sorted_array_search_core (
  input  logic       clk,
  input  logic       rst,
  rsas_req_if.sink   req,
  rsas_rsp_if.source rsp
);
  import rsas_pkg::*;

  logic          acc;
  logic          idle;
  req_t          req_item;
  logic          res_valid;
  res_t          res;
  logic          res_take;
  logic          we;
  logic [AW-1:0] waddr;
  logic [DW-1:0] wdata;
  logic [AW-1:0] raddr;
  logic [DW-1:0] rdata;

  logic          out_valid;
  res_t          out_res;

  assign req.ready      = idle;
  assign acc            = req.valid && idle;
  assign req_item.cmd   = req.cmd;
  assign req_item.value = req.value;

  // result register: free when empty or being drained this cycle
  assign res_take = !out_valid || rsp.ready;

  rsas_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .acc       (acc),
    .req       (req_item),
    .idle      (idle),
    .res_valid (res_valid),
    .res       (res),
    .res_take  (res_take),
    .we        (we),
    .waddr     (waddr),
    .wdata     (wdata),
    .raddr     (raddr),
    .rdata     (rdata)
  );

  // appends and lookup reads never overlap on an entry, no bypass needed
  rsas_ram #(
    .WIDTH (DW),
    .ABITS (AW)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_valid && res_take) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_take) begin
      out_res <= res;
    end
  end

  assign rsp.valid    = out_valid;
  assign rsp.found    = out_res.found;
  assign rsp.position = out_res.position;

endmodule
